[design/sps_pkg.sv]
// Shared types and constants for the servo pulse sequencer.
package sps_pkg;

    localparam int DEF_MAX_CHANNELS = 2;

    localparam int WIDTH_W  = 11;
    localparam int VALUE_W  = 12;
    localparam int TICKS_W  = 13;
    localparam int ANGLE_W  = 10;
    localparam int PROD_W   = 24;
    localparam int DIVD_W   = 24;
    localparam int DEN_W    = 10;
    localparam int CFG_IDX_W = 3;

    localparam logic [TICKS_W-1:0] PULSE_EXTRA = 13'd20;
    localparam logic [WIDTH_W-1:0] WIDTH_TOP   = 11'd2047;

    // input kinds
    localparam logic [2:0] KIND_TICK  = 3'd0;
    localparam logic [2:0] KIND_START = 3'd1;
    localparam logic [2:0] KIND_SET   = 3'd2;
    localparam logic [2:0] KIND_ANGLE = 3'd3;
    localparam logic [2:0] KIND_INC   = 3'd4;
    localparam logic [2:0] KIND_DEC   = 3'd5;
    localparam logic [2:0] KIND_RESET = 3'd6;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ACTIVE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_WIDTH = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_CENTER    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_ANGLE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_ANGLE = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_REV_MASK  = 3'd6;

    // configuration reset values
    localparam logic [1:0]         RST_ACTIVE    = 2'd2;
    localparam logic [WIDTH_W-1:0] RST_MIN_WIDTH = 11'd50;
    localparam logic [WIDTH_W-1:0] RST_MAX_WIDTH = 11'd250;
    localparam logic [WIDTH_W-1:0] RST_CENTER    = 11'd150;
    localparam logic [ANGLE_W-1:0] RST_MIN_ANGLE = 10'h3A6;  // -90
    localparam logic [ANGLE_W-1:0] RST_MAX_ANGLE = 10'd90;
    localparam logic [1:0]         RST_REV_MASK  = 2'd0;

    typedef struct packed {
        logic [2:0]                kind;
        logic                      channel;
        logic signed [VALUE_W-1:0] value;
    } sps_in_t;

    typedef struct packed {
        logic [1:0]         pin_levels;
        logic               busy_res;
        logic               frame_done;
        logic [WIDTH_W-1:0] width_readback;
    } sps_out_t;

endpackage

[design/sps_div.sv]
// Iterative unsigned divider, two quotient bits per cycle.
module sps_div
    import sps_pkg::*;
(
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              start,
    input  logic [DIVD_W-1:0] dividend,
    input  logic [DEN_W-1:0]  divisor,
    output logic [DIVD_W-1:0] quotient,
    output logic              done
);

    localparam int ITER  = DIVD_W / 2;
    localparam int CNT_W = $clog2(ITER);

    logic [DEN_W:0]     rem_reg, rem_next;
    logic [DIVD_W-1:0]  quo_reg, quo_next;
    logic [CNT_W-1:0]   cnt_reg, cnt_next;
    logic               run_reg, run_next;
    logic               done_reg, done_next;

    always_comb begin
        logic [DEN_W+1:0] tmp;
        logic [DEN_W:0]   r;
        logic [DIVD_W-1:0] q;
        r = rem_reg;
        q = quo_reg;
        for (int k = 0; k < 2; k++) begin
            tmp = {r, q[DIVD_W-1]};
            q   = {q[DIVD_W-2:0], 1'b0};
            if (tmp >= {2'b00, divisor}) begin
                tmp  = tmp - {2'b00, divisor};
                q[0] = 1'b1;
            end
            r = tmp[DEN_W:0];
        end

        rem_next  = rem_reg;
        quo_next  = quo_reg;
        cnt_next  = cnt_reg;
        run_next  = run_reg;
        done_next = 1'b0;
        if (start) begin
            rem_next = '0;
            quo_next = dividend;
            cnt_next = '0;
            run_next = 1'b1;
        end else if (run_reg) begin
            rem_next = r;
            quo_next = q;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ITER - 1)) begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            run_reg  <= run_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

    assign quotient = quo_reg;
    assign done     = done_reg;

endmodule

[design/servo_pulse_sequencer_top.sv]
// Servo pulse sequencer: command decode, frame sequencing and result register.
// Every item is decoded and reported through the result register; start and a pulse-ending
// tick first scan the channels until one has a nonzero pulse or none is left; reset-all
// first sets each active channel to center; set-angle multiplies, runs the two-bit divider
// and writes, or writes center on a zero angle span. s_ready is high only while idle.
// Reset (aresetn low, synchronous): widths zero, frame idle, registers at defaults.
module servo_pulse_sequencer_top
    import sps_pkg::*;
#(
    parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  sps_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output sps_out_t             m_data,
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WIDTH_W-1:0]   cfg_wdata
);

    localparam int CH_W  = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int PTR_W = $clog2(MAX_CHANNELS + 1);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_CLR  = 3'd3;
    localparam logic [2:0] S_MUL  = 3'd4;
    localparam logic [2:0] S_DIVS = 3'd5;
    localparam logic [2:0] S_DIV  = 3'd6;
    localparam logic [2:0] S_OUT  = 3'd7;

    // configuration
    logic [1:0]         active_reg;
    logic [WIDTH_W-1:0] min_w_reg, max_w_reg, center_reg;
    logic [ANGLE_W-1:0] min_a_reg, max_a_reg;
    logic [1:0]         rev_reg;

    logic [2:0]                state_reg, state_next;
    logic [2:0]                kind_reg;
    logic                      ch_reg;
    logic signed [VALUE_W-1:0] value_reg;
    logic [WIDTH_W-1:0]        widths_reg [MAX_CHANNELS];
    logic                      busy_reg, busy_next;
    logic [CH_W-1:0]           cur_reg, cur_next;
    logic [TICKS_W-1:0]        ticks_reg, ticks_next;
    logic                      done_reg, done_next;
    logic [PTR_W-1:0]          ptr_reg, ptr_next;
    logic signed [PROD_W-1:0]  prod_reg;
    logic signed [WIDTH_W-1:0] span_reg, span_next;
    logic                      neg_reg;
    logic                      m_valid_reg, m_valid_next;
    sps_out_t                  m_data_reg, m_data_next;

    logic                      wr_en;
    logic [WIDTH_W-1:0]        wr_data;
    logic [WIDTH_W-1:0]        width_rd;
    logic [PTR_W-1:0]          ch_ext, cnt;
    logic                      ch_ok;
    logic signed [VALUE_W-1:0] wdiff;
    logic signed [WIDTH_W-1:0] span;
    logic                      rev_bit;
    logic [TICKS_W-1:0]        plen;
    logic [WIDTH_W-1:0]        angle_w;
    logic                      div_start, div_done;
    logic [DIVD_W-1:0]         div_num, div_quo;
    logic [DEN_W-1:0]          div_den;
    logic [1:0]                pins;

    assign ch_ext = PTR_W'(ch_reg);
    assign ch_ok  = ch_ext < PTR_W'(MAX_CHANNELS);
    assign cnt    = (32'(active_reg) > MAX_CHANNELS) ? PTR_W'(MAX_CHANNELS)
                                                     : PTR_W'(active_reg);
    assign width_rd = (ptr_reg < PTR_W'(MAX_CHANNELS)) ? widths_reg[ptr_reg[CH_W-1:0]] : '0;

    assign wdiff = $signed({1'b0, max_w_reg}) - $signed({1'b0, min_w_reg});
    assign span  = $signed({max_a_reg[ANGLE_W-1], max_a_reg})
                 - $signed({min_a_reg[ANGLE_W-1], min_a_reg});

    // pulse length of the channel under the scan pointer, floored at zero
    assign rev_bit = (32'(ptr_reg) < 2) && rev_reg[ptr_reg[0]];
    always_comb begin
        logic signed [TICKS_W:0] mirrored;
        mirrored = $signed({3'b000, max_w_reg}) - $signed({3'b000, width_rd})
                 + $signed({3'b000, min_w_reg}) + $signed({1'b0, PULSE_EXTRA});
        if (rev_bit)
            plen = mirrored[TICKS_W] ? '0 : mirrored[TICKS_W-1:0];
        else
            plen = {2'b00, width_rd} + PULSE_EXTRA;
    end

    // divider operands: sign-magnitude around the unsigned divider unit
    always_comb begin
        logic [PROD_W-1:0]  pabs;
        logic [WIDTH_W-1:0] sabs;
        pabs    = prod_reg[PROD_W-1] ? PROD_W'(-prod_reg) : PROD_W'(prod_reg);
        sabs    = span_reg[WIDTH_W-1] ? WIDTH_W'(-span_reg) : WIDTH_W'(span_reg);
        div_num = DIVD_W'(pabs);
        div_den = sabs[DEN_W-1:0];
    end

    always_comb begin
        logic signed [DIVD_W:0]   q_s;
        logic signed [DIVD_W+1:0] sum;
        q_s = neg_reg ? -$signed({1'b0, div_quo}) : $signed({1'b0, div_quo});
        sum = $signed({q_s[DIVD_W], q_s}) + $signed({15'b0, center_reg});
        if (sum[DIVD_W+1])
            angle_w = '0;
        else if (sum > $signed({15'b0, WIDTH_TOP}))
            angle_w = WIDTH_TOP;
        else
            angle_w = sum[WIDTH_W-1:0];
    end

    sps_div u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_num),
        .divisor  (div_den),
        .quotient (div_quo),
        .done     (div_done)
    );

    assign pins = (busy_reg && 32'(cur_reg) < 2) ? (2'b01 << cur_reg[0]) : 2'b00;

    always_comb begin
        logic [TICKS_W-1:0] ticks_dec;
        ticks_dec    = (ticks_reg != '0) ? ticks_reg - 1'b1 : '0;
        state_next   = state_reg;
        busy_next    = busy_reg;
        cur_next     = cur_reg;
        ticks_next   = ticks_reg;
        done_next    = done_reg;
        ptr_next     = ptr_reg;
        span_next    = span_reg;
        wr_en        = 1'b0;
        wr_data      = width_rd;
        div_start    = 1'b0;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        if (m_valid_reg && m_ready)
            m_valid_next = 1'b0;

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    state_next = S_EXEC;
                    ptr_next   = PTR_W'(s_data.channel);
                    done_next  = 1'b0;
                end
            end
            S_EXEC: begin
                state_next = S_OUT;
                case (kind_reg)
                    KIND_TICK: begin
                        if (busy_reg) begin
                            ticks_next = ticks_dec;
                            if (ticks_dec == '0) begin
                                ptr_next   = PTR_W'(cur_reg) + PTR_W'(1);
                                state_next = S_SCAN;
                            end
                        end
                    end
                    KIND_START: begin
                        if (!busy_reg) begin
                            ptr_next   = '0;
                            state_next = S_SCAN;
                        end
                    end
                    KIND_SET: begin
                        wr_en   = ch_ok;
                        wr_data = value_reg[VALUE_W-1] ? '0 : value_reg[WIDTH_W-1:0];
                    end
                    KIND_ANGLE: begin
                        span_next = span;
                        if (ch_ok && span == '0) begin
                            wr_en   = 1'b1;
                            wr_data = center_reg;
                        end else if (ch_ok) begin
                            state_next = S_MUL;
                        end
                    end
                    KIND_INC: begin
                        wr_en   = ch_ok && ({1'b0, width_rd} + 12'd1 <= {1'b0, max_w_reg});
                        wr_data = width_rd + 1'b1;
                    end
                    KIND_DEC: begin
                        wr_en   = ch_ok && (width_rd > min_w_reg);
                        wr_data = width_rd - 1'b1;
                    end
                    KIND_RESET: begin
                        ptr_next   = '0;
                        state_next = S_CLR;
                    end
                    default: ;
                endcase
                if (state_next == S_OUT)
                    ptr_next = ch_ext;
            end
            S_SCAN: begin
                if (ptr_reg >= cnt) begin
                    busy_next  = 1'b0;
                    cur_next   = '0;
                    ticks_next = '0;
                    done_next  = 1'b1;
                    ptr_next   = ch_ext;
                    state_next = S_OUT;
                end else if (plen != '0) begin
                    busy_next  = 1'b1;
                    cur_next   = ptr_reg[CH_W-1:0];
                    ticks_next = plen;
                    ptr_next   = ch_ext;
                    state_next = S_OUT;
                end else begin
                    ptr_next = ptr_reg + 1'b1;
                end
            end
            S_CLR: begin
                if (ptr_reg < cnt) begin
                    wr_en    = 1'b1;
                    wr_data  = center_reg;
                    ptr_next = ptr_reg + 1'b1;
                end else begin
                    ptr_next   = ch_ext;
                    state_next = S_OUT;
                end
            end
            S_MUL: begin
                state_next = S_DIVS;
            end
            S_DIVS: begin
                div_start  = 1'b1;
                state_next = S_DIV;
            end
            S_DIV: begin
                if (div_done) begin
                    wr_en      = 1'b1;
                    wr_data    = angle_w;
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next               = 1'b1;
                    m_data_next.pin_levels     = pins;
                    m_data_next.busy_res       = busy_reg;
                    m_data_next.frame_done     = done_reg;
                    m_data_next.width_readback = ch_ok ? width_rd : '0;
                    state_next                 = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            busy_reg    <= 1'b0;
            cur_reg     <= '0;
            ticks_reg   <= '0;
            done_reg    <= 1'b0;
            ptr_reg     <= '0;
            m_valid_reg <= 1'b0;
            for (int i = 0; i < MAX_CHANNELS; i++)
                widths_reg[i] <= '0;
        end else begin
            state_reg   <= state_next;
            busy_reg    <= busy_next;
            cur_reg     <= cur_next;
            ticks_reg   <= ticks_next;
            done_reg    <= done_next;
            ptr_reg     <= ptr_next;
            m_valid_reg <= m_valid_next;
            if (wr_en && ptr_reg < PTR_W'(MAX_CHANNELS))
                widths_reg[ptr_reg[CH_W-1:0]] <= wr_data;
        end
        if (state_reg == S_IDLE && s_valid) begin
            kind_reg  <= s_data.kind;
            ch_reg    <= s_data.channel;
            value_reg <= s_data.value;
        end
        if (state_reg == S_MUL)
            prod_reg <= value_reg * wdiff;
        if (state_reg == S_DIVS)
            neg_reg <= prod_reg[PROD_W-1] ^ span_reg[WIDTH_W-1];
        span_reg   <= span_next;
        m_data_reg <= m_data_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= RST_ACTIVE;
            min_w_reg  <= RST_MIN_WIDTH;
            max_w_reg  <= RST_MAX_WIDTH;
            center_reg <= RST_CENTER;
            min_a_reg  <= RST_MIN_ANGLE;
            max_a_reg  <= RST_MAX_ANGLE;
            rev_reg    <= RST_REV_MASK;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_ACTIVE:    active_reg <= cfg_wdata[1:0];
                CFG_MIN_WIDTH: min_w_reg  <= cfg_wdata;
                CFG_MAX_WIDTH: max_w_reg  <= cfg_wdata;
                CFG_CENTER:    center_reg <= cfg_wdata;
                CFG_MIN_ANGLE: min_a_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_MAX_ANGLE: max_a_reg  <= cfg_wdata[ANGLE_W-1:0];
                CFG_REV_MASK:  rev_reg    <= cfg_wdata[1:0];
                default: ;
            endcase
        end
    end

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a running frame always has time left once the sequencer settles
    a_busy_ticks: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_IDLE && busy_reg) |-> ticks_reg != '0)
        else $error("frame busy with no ticks left");

    a_done_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.frame_done) |-> !m_data_reg.busy_res)
        else $error("frame_done reported while busy");

    a_pins_onehot: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0(m_data_reg.pin_levels))
        else $error("more than one pin high");

    a_div_owner: assert property (@(posedge aclk) disable iff (!aresetn)
        div_done |-> state_reg == S_DIV)
        else $error("divider finished outside angle sequence");

    a_accept_moves: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_valid && s_ready) |=> state_reg == S_EXEC)
        else $error("accepted item not executed");

endmodule
